>>> sv/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and operator helpers of the infix to postfix
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

    // ascii characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_POW    = 8'h5E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // stack entry codes
    typedef logic [2:0] t_code;
    localparam t_code OP_OPEN = 3'd0;
    localparam t_code OP_ADD  = 3'd1;
    localparam t_code OP_SUB  = 3'd2;
    localparam t_code OP_MUL  = 3'd3;
    localparam t_code OP_DIV  = 3'd4;
    localparam t_code OP_POW  = 3'd5;

    // command kinds from the front end
    typedef logic [2:0] t_kind;
    localparam t_kind K_CHAR  = 3'd0;
    localparam t_kind K_OPEN  = 3'd1;
    localparam t_kind K_CLOSE = 3'd2;
    localparam t_kind K_END   = 3'd3;
    localparam t_kind K_OPER  = 3'd4;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        t_code      code;
    } t_cmd;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       eoe;
        logic       err;
    } t_res;

    function automatic logic [1:0] op_rank(input t_code code);
        logic [1:0] r;
        case (code)
            OP_POW:         r = 2'd3;
            OP_MUL, OP_DIV: r = 2'd2;
            OP_ADD, OP_SUB: r = 2'd1;
            default:        r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(input t_code code);
        logic [7:0] c;
        case (code)
            OP_ADD:  c = CH_ADD;
            OP_SUB:  c = CH_SUB;
            OP_MUL:  c = CH_MUL;
            OP_DIV:  c = CH_DIV;
            OP_POW:  c = CH_POW;
            default: c = CH_LPAREN;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/itp_front.sv
// ----------------------------------------------------------------------------
// itp_front
// Classifies incoming characters into stack commands and buffers them in a
// two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_in_char,
    output logic               o_full,
    output logic               o_cmd_valid,
    output itp_pkg::t_cmd      o_cmd,
    input  wire logic          i_cmd_take
);

    itp_pkg::t_cmd r_q [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_cnt, n_cnt;
    itp_pkg::t_cmd cls_cmd;
    logic          cls_keep;
    logic          wr_en, rd_en;

    always_comb begin
        cls_cmd.kind = itp_pkg::K_CHAR;
        cls_cmd.ch   = i_in_char;
        cls_cmd.code = itp_pkg::OP_OPEN;
        cls_keep     = 1'b1;
        if ((i_in_char >= itp_pkg::CH_UP_A && i_in_char <= itp_pkg::CH_UP_Z) ||
            (i_in_char >= itp_pkg::CH_LO_A && i_in_char <= itp_pkg::CH_LO_Z) ||
            (i_in_char >= itp_pkg::CH_0 && i_in_char <= itp_pkg::CH_9)) begin
            cls_cmd.kind = itp_pkg::K_CHAR;
        end else begin
            case (i_in_char)
                itp_pkg::CH_LPAREN: cls_cmd.kind = itp_pkg::K_OPEN;
                itp_pkg::CH_RPAREN: cls_cmd.kind = itp_pkg::K_CLOSE;
                itp_pkg::CH_NUL:    cls_cmd.kind = itp_pkg::K_END;
                itp_pkg::CH_ADD: begin
                    cls_cmd.kind = itp_pkg::K_OPER;
                    cls_cmd.code = itp_pkg::OP_ADD;
                end
                itp_pkg::CH_SUB: begin
                    cls_cmd.kind = itp_pkg::K_OPER;
                    cls_cmd.code = itp_pkg::OP_SUB;
                end
                itp_pkg::CH_MUL: begin
                    cls_cmd.kind = itp_pkg::K_OPER;
                    cls_cmd.code = itp_pkg::OP_MUL;
                end
                itp_pkg::CH_DIV: begin
                    cls_cmd.kind = itp_pkg::K_OPER;
                    cls_cmd.code = itp_pkg::OP_DIV;
                end
                itp_pkg::CH_POW: begin
                    cls_cmd.kind = itp_pkg::K_OPER;
                    cls_cmd.code = itp_pkg::OP_POW;
                end
                // anything else is accepted and dropped
                default: cls_keep = 1'b0;
            endcase
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign wr_en       = i_push && !o_full && cls_keep;
    assign rd_en       = i_cmd_take && o_cmd_valid;

    always_comb begin
        case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= cls_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/itp_back.sv
// ----------------------------------------------------------------------------
// itp_back
// Stack engine: one command step per cycle on the operator stack, stalling while
// its result meets a full result queue; pops at most one operator per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_back #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire itp_pkg::t_cmd i_cmd,
    output logic               o_cmd_take,
    output logic               o_res_push,
    output itp_pkg::t_res      o_res,
    input  wire logic          i_res_full
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    // top of stack lives in r_top, the entries below it in r_mem
    itp_pkg::t_code r_mem [STACK_DEPTH];
    itp_pkg::t_code r_rd;
    itp_pkg::t_code r_top, n_top;
    logic [CNT_W-1:0] r_cnt, n_cnt, rd_cnt;
    logic           r_err, n_err;
    logic           has_top, below_ok, stk_full;
    logic           do_push, do_pop;
    itp_pkg::t_code push_code;
    logic           mem_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic           step_ok;

    assign has_top  = (r_cnt != '0);
    assign below_ok = (r_cnt > CNT_W'(1));
    assign stk_full = (r_cnt == CNT_W'(STACK_DEPTH));

    always_comb begin
        o_cmd_take = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{ch: i_cmd.ch, last: 1'b1, eoe: 1'b0, err: 1'b0};
        do_push    = 1'b0;
        do_pop     = 1'b0;
        push_code  = i_cmd.code;
        n_err      = r_err;
        step_ok    = i_cmd_valid;
        if (step_ok) begin
            unique case (i_cmd.kind)
                itp_pkg::K_CHAR: begin
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        o_cmd_take = 1'b1;
                    end
                end
                itp_pkg::K_OPEN: begin
                    do_push    = 1'b1;
                    push_code  = itp_pkg::OP_OPEN;
                    o_cmd_take = 1'b1;
                end
                itp_pkg::K_OPER: begin
                    if (has_top &&
                        itp_pkg::op_rank(r_top) >= itp_pkg::op_rank(i_cmd.code)) begin
                        if (!i_res_full) begin
                            o_res_push = 1'b1;
                            o_res.ch   = itp_pkg::code_char(r_top);
                            // last unless the entry below also pops
                            o_res.last = !(below_ok && itp_pkg::op_rank(r_rd) >=
                                           itp_pkg::op_rank(i_cmd.code));
                            do_pop     = 1'b1;
                        end
                    end else begin
                        do_push    = 1'b1;
                        o_cmd_take = 1'b1;
                    end
                end
                itp_pkg::K_CLOSE: begin
                    if (!has_top) begin
                        n_err      = 1'b1;
                        o_cmd_take = 1'b1;
                    end else if (r_top == itp_pkg::OP_OPEN) begin
                        do_pop     = 1'b1;
                        o_cmd_take = 1'b1;
                    end else if (!i_res_full) begin
                        o_res_push = 1'b1;
                        o_res.ch   = itp_pkg::code_char(r_top);
                        o_res.last = !(below_ok && r_rd != itp_pkg::OP_OPEN);
                        do_pop     = 1'b1;
                    end
                end
                itp_pkg::K_END: begin
                    if (has_top && r_top != itp_pkg::OP_OPEN) begin
                        if (!i_res_full) begin
                            o_res_push = 1'b1;
                            o_res.ch   = itp_pkg::code_char(r_top);
                            o_res.last = 1'b0;
                            do_pop     = 1'b1;
                        end
                    end else if (!i_res_full) begin
                        o_res_push = 1'b1;
                        o_res.ch   = itp_pkg::CH_LF;
                        o_res.eoe  = 1'b1;
                        o_res.err  = r_err;
                        n_err      = 1'b0;
                        o_cmd_take = 1'b1;
                    end
                end
                default: o_cmd_take = 1'b1;
            endcase
        end
        // a push onto a full stack is dropped and flagged
        if (do_push && stk_full) begin
            n_err = 1'b1;
        end
    end

    always_comb begin
        n_top  = r_top;
        n_cnt  = r_cnt;
        mem_we = 1'b0;
        waddr  = ADDR_W'(r_cnt - CNT_W'(1));
        if (do_push) begin
            if (!stk_full) begin
                mem_we = has_top;
                n_top  = push_code;
                n_cnt  = r_cnt + CNT_W'(1);
            end
        end else if (do_pop) begin
            n_top = r_rd;
            n_cnt = r_cnt - CNT_W'(1);
        end
        // terminator clears the whole stack once the newline goes out
        if (o_cmd_take && i_cmd.kind == itp_pkg::K_END) begin
            n_cnt = '0;
        end
        rd_cnt = n_cnt - CNT_W'(2);
        raddr  = rd_cnt[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_err <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    // registered read of the entry just below the next top, write-first
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= r_top;
        end
        if (mem_we && waddr == raddr) begin
            r_rd <= r_top;
        end else begin
            r_rd <= r_mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/itp_resq.sv
// ----------------------------------------------------------------------------
// itp_resq
// Two-entry result queue between the stack engine and the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module itp_resq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire itp_pkg::t_res i_res,
    output logic               o_full,
    output logic               o_empty,
    output itp_pkg::t_res      o_res,
    input  wire logic          i_pop
);

    itp_pkg::t_res r_q [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_cnt, n_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_q[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

endmodule

`default_nettype wire

>>> sv/infix_to_postfix_converter_top.sv
// flow: the command queue takes new characters while the stack engine works on
//   earlier ones; results are held in the result queue that drives the outputs
// pops: letters, digits and '(' pop nothing; an operator, ')' or the terminator
//   first pops each operator it displaces, the stack engine popping one entry per
//   cycle from its single-write stack memory while the result queue has room
// reset: synchronous, clears both queues, stack count and error flag
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: classifier front end, command queue, stack engine
// and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_in_char,
    output logic            o_full,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_out_char,
    output logic            o_last_of_run,
    output logic            o_expression_end,
    output logic            o_error
);

    itp_pkg::t_cmd cmd;
    logic          cmd_valid, cmd_take;
    itp_pkg::t_res eng_res, out_res;
    logic          res_push, res_full;

    itp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in_char   (i_in_char),
        .o_full      (o_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_res_push  (res_push),
        .o_res       (eng_res),
        .i_res_full  (res_full)
    );

    itp_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (eng_res),
        .o_full  (res_full),
        .o_empty (o_empty),
        .o_res   (out_res),
        .i_pop   (i_pop)
    );

    assign o_out_char       = out_res.ch;
    assign o_last_of_run    = out_res.last;
    assign o_expression_end = out_res.eoe;
    assign o_error          = out_res.err;

endmodule

`default_nettype wire

>>> tb/infix_to_postfix_converter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_tb
// Drives infix characters into the converter and checks each postfix
// transaction against a shunting-yard predictor kept in the bench. A short
// table of directed characters comes first, then random expressions: mostly
// well formed, some noise, broken nesting and stack overflow runs.
// ----------------------------------------------------------------------------

module infix_to_postfix_converter_top_tb;

    localparam int STACK_DEPTH = 32;
    localparam int TARGET_CHARS = 430;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_PRINTS = 50;

    typedef struct packed {
        logic [7:0]    ch;
        logic          typed;
        itp_pkg::t_res res;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_push;
    logic [7:0] i_in_char;
    logic       o_full;
    logic       o_empty;
    logic       i_pop;
    logic [7:0] o_out_char;
    logic       o_last_of_run;
    logic       o_expression_end;
    logic       o_error;

    // predictor state
    itp_pkg::t_code op_stack [STACK_DEPTH];
    int unsigned    op_count;
    logic           paren_error;
    itp_pkg::t_res  step_results[$];

    itp_pkg::t_res  postfix_expected[$];
    t_dir_row       directed_rows[$];
    logic [7:0]     random_chars[$];

    int  tx_idle_pct;
    int  rx_idle_pct;
    int  accepted_count;
    int  total_chars;
    int  mismatch_count;
    int  hold_left;
    bit  hold_done;
    bit  reset_done;

    infix_to_postfix_converter_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .i_in_char        (i_in_char),
        .o_full           (o_full),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_out_char       (o_out_char),
        .o_last_of_run    (o_last_of_run),
        .o_expression_end (o_expression_end),
        .o_error          (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(64'd20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic bit is_operand(input logic [7:0] ch);
        return (ch >= itp_pkg::CH_UP_A && ch <= itp_pkg::CH_UP_Z) ||
               (ch >= itp_pkg::CH_LO_A && ch <= itp_pkg::CH_LO_Z) ||
               (ch >= itp_pkg::CH_0 && ch <= itp_pkg::CH_9);
    endfunction

    function automatic itp_pkg::t_code operator_code(input logic [7:0] ch);
        itp_pkg::t_code c;
        case (ch)
            itp_pkg::CH_ADD: c = itp_pkg::OP_ADD;
            itp_pkg::CH_SUB: c = itp_pkg::OP_SUB;
            itp_pkg::CH_MUL: c = itp_pkg::OP_MUL;
            itp_pkg::CH_DIV: c = itp_pkg::OP_DIV;
            itp_pkg::CH_POW: c = itp_pkg::OP_POW;
            default:         c = itp_pkg::OP_OPEN;
        endcase
        return c;
    endfunction

    function automatic bit is_handled(input logic [7:0] ch);
        return is_operand(ch) || ch == itp_pkg::CH_LPAREN || ch == itp_pkg::CH_RPAREN ||
               ch == itp_pkg::CH_NUL || operator_code(ch) != itp_pkg::OP_OPEN;
    endfunction

    function automatic int precedence(input itp_pkg::t_code c);
        int p;
        case (c)
            itp_pkg::OP_POW:                 p = 3;
            itp_pkg::OP_MUL, itp_pkg::OP_DIV: p = 2;
            itp_pkg::OP_ADD, itp_pkg::OP_SUB: p = 1;
            default:                         p = 0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] op_symbol(input itp_pkg::t_code c);
        logic [7:0] s;
        case (c)
            itp_pkg::OP_ADD: s = itp_pkg::CH_ADD;
            itp_pkg::OP_SUB: s = itp_pkg::CH_SUB;
            itp_pkg::OP_MUL: s = itp_pkg::CH_MUL;
            itp_pkg::OP_DIV: s = itp_pkg::CH_DIV;
            itp_pkg::OP_POW: s = itp_pkg::CH_POW;
            default:         s = itp_pkg::CH_LPAREN;
        endcase
        return s;
    endfunction

    function automatic itp_pkg::t_res make_res(input logic [7:0] ch, input logic last,
                                               input logic eoe, input logic err);
        itp_pkg::t_res r;
        r.ch   = ch;
        r.last = last;
        r.eoe  = eoe;
        r.err  = err;
        return r;
    endfunction

    function automatic void stack_push(input itp_pkg::t_code c);
        if (op_count < STACK_DEPTH) begin
            op_stack[op_count] = c;
            op_count++;
        end else begin
            paren_error = 1'b1;
        end
    endfunction

    // pops operators down to the nearest stored '(', which is consumed too
    function automatic bit drain_to_open();
        itp_pkg::t_code c;
        while (op_count > 0) begin
            op_count--;
            c = op_stack[op_count];
            if (c == itp_pkg::OP_OPEN) return 1'b1;
            step_results.push_back(make_res(op_symbol(c), 1'b0, 1'b0, 1'b0));
        end
        return 1'b0;
    endfunction

    function automatic void shunt_char(input logic [7:0] ch);
        itp_pkg::t_code c;
        bit             found;
        step_results.delete();
        c = operator_code(ch);
        if (is_operand(ch)) begin
            step_results.push_back(make_res(ch, 1'b0, 1'b0, 1'b0));
        end else if (ch == itp_pkg::CH_LPAREN) begin
            stack_push(itp_pkg::OP_OPEN);
        end else if (ch == itp_pkg::CH_RPAREN) begin
            found = drain_to_open();
            if (!found) paren_error = 1'b1;
        end else if (ch == itp_pkg::CH_NUL) begin
            found = drain_to_open();
            step_results.push_back(make_res(itp_pkg::CH_LF, 1'b0, 1'b1, paren_error));
            op_count = 0;
            paren_error = 1'b0;
        end else if (c != itp_pkg::OP_OPEN) begin
            while (op_count > 0 && precedence(op_stack[op_count - 1]) >= precedence(c)) begin
                op_count--;
                step_results.push_back(make_res(op_symbol(op_stack[op_count]),
                                                1'b0, 1'b0, 1'b0));
            end
            stack_push(c);
        end
        if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_operand();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26) return 8'(itp_pkg::CH_UP_A + r);
        if (r < 52) return 8'(itp_pkg::CH_LO_A + r - 26);
        return 8'(itp_pkg::CH_0 + r - 52);
    endfunction

    function automatic logic [7:0] rand_operator();
        logic [7:0] s;
        case ($urandom_range(0, 4))
            0:       s = itp_pkg::CH_ADD;
            1:       s = itp_pkg::CH_SUB;
            2:       s = itp_pkg::CH_MUL;
            3:       s = itp_pkg::CH_DIV;
            default: s = itp_pkg::CH_POW;
        endcase
        return s;
    endfunction

    function automatic int add_char(input logic [7:0] ch);
        random_chars.push_back(ch);
        return is_handled(ch) ? 1 : 0;
    endfunction

    // returns the number of characters that the block acts on
    function automatic int add_expression(input bit force_deep);
        int kind;
        int n;
        int depth;
        int cnt;
        cnt = 0;
        kind = force_deep ? 99 : $urandom_range(0, 99);
        if (kind < 72) begin
            depth = 0;
            n = $urandom_range(1, 7);
            for (int i = 0; i < n; i++) begin
                while ($urandom_range(0, 3) == 0 && depth < 6) begin
                    cnt += add_char(itp_pkg::CH_LPAREN);
                    depth++;
                end
                cnt += add_char(rand_operand());
                while (depth > 0 && $urandom_range(0, 2) == 0) begin
                    cnt += add_char(itp_pkg::CH_RPAREN);
                    depth--;
                end
                if (i < n - 1) cnt += add_char(rand_operator());
            end
            while (depth > 0) begin
                cnt += add_char(itp_pkg::CH_RPAREN);
                depth--;
            end
        end else if (kind < 82) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) cnt += add_char(8'($urandom_range(1, 255)));
        end else if (kind < 95) begin
            // operands, operators and unbalanced parentheses in any order
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0:       cnt += add_char(rand_operand());
                    1:       cnt += add_char(rand_operator());
                    2:       cnt += add_char(itp_pkg::CH_LPAREN);
                    default: cnt += add_char(itp_pkg::CH_RPAREN);
                endcase
            end
        end else begin
            // deep nesting, usually past the stack depth
            n = force_deep ? STACK_DEPTH + 4 : $urandom_range(20, 40);
            for (int i = 0; i < n; i++) begin
                if (!force_deep && $urandom_range(0, 1) == 1) begin
                    cnt += add_char(rand_operand());
                    cnt += add_char(rand_operator());
                end
                cnt += add_char(itp_pkg::CH_LPAREN);
            end
            cnt += add_char(rand_operand());
            if ($urandom_range(0, 1) == 1) cnt += add_char(itp_pkg::CH_RPAREN);
        end
        cnt += add_char(itp_pkg::CH_NUL);
        return cnt;
    endfunction

    function automatic void add_row(input logic [7:0] ch, input logic typed,
                                    input itp_pkg::t_res res);
        t_dir_row row;
        row.ch = ch;
        row.typed = typed;
        row.res = res;
        directed_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // driving and checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_char(input logic [7:0] ch, input logic typed,
                             input itp_pkg::t_res typed_res);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_push <= 1'b0;
            i_in_char <= 8'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_in_char <= ch;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        shunt_char(ch);
        if (typed) begin
            postfix_expected.push_back(typed_res);
        end else begin
            foreach (step_results[k]) postfix_expected.push_back(step_results[k]);
        end
        accepted_count++;
        @(negedge i_clk);
    endtask

    task automatic set_idle_phase(input int idx);
        if (idx < total_chars / 3) begin
            tx_idle_pct = 6;
            rx_idle_pct = 81;
        end else if (idx < 2 * total_chars / 3) begin
            tx_idle_pct = 81;
            rx_idle_pct = 6;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // receiver: random stalls plus one long hold-off while the input keeps flowing
    always @(negedge i_clk) begin
        if (!reset_done) begin
            i_pop <= 1'b0;
        end else begin
            if (!hold_done && accepted_count >= total_chars / 6) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        itp_pkg::t_res want;
        if (reset_done && i_pop && !o_empty) begin
            if (postfix_expected.size() == 0) begin
                report_mismatch("unexpected transaction, out_char", o_out_char, 8'h00);
            end else begin
                want = postfix_expected.pop_front();
                if (o_out_char !== want.ch)
                    report_mismatch("out_char", o_out_char, want.ch);
                if (o_last_of_run !== want.last)
                    report_mismatch("last_of_run", 8'(o_last_of_run), 8'(want.last));
                if (o_expression_end !== want.eoe)
                    report_mismatch("expression_end", 8'(o_expression_end), 8'(want.eoe));
                if (o_error !== want.err)
                    report_mismatch("error", 8'(o_error), 8'(want.err));
            end
        end
    end

    initial begin
        int idx;
        int handled;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_in_char = 8'h00;
        i_pop = 1'b0;
        reset_done = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        accepted_count = 0;
        mismatch_count = 0;
        op_count = 0;
        paren_error = 1'b0;
        foreach (op_stack[k]) op_stack[k] = itp_pkg::OP_OPEN;

        // extremes of the operand classes, then every operator, an unmatched ')' and a stray '('
        add_row(itp_pkg::CH_UP_A, 1'b1, make_res(itp_pkg::CH_UP_A, 1'b1, 1'b0, 1'b0));
        add_row(itp_pkg::CH_UP_Z, 1'b1, make_res(itp_pkg::CH_UP_Z, 1'b1, 1'b0, 1'b0));
        add_row(itp_pkg::CH_LO_A, 1'b1, make_res(itp_pkg::CH_LO_A, 1'b1, 1'b0, 1'b0));
        add_row(itp_pkg::CH_LO_Z, 1'b1, make_res(itp_pkg::CH_LO_Z, 1'b1, 1'b0, 1'b0));
        add_row(itp_pkg::CH_0,    1'b1, make_res(itp_pkg::CH_0, 1'b1, 1'b0, 1'b0));
        add_row(itp_pkg::CH_9,    1'b1, make_res(itp_pkg::CH_9, 1'b1, 1'b0, 1'b0));
        add_row(8'h40,              1'b0, '0);
        add_row(itp_pkg::CH_ADD,    1'b0, '0);
        add_row("b",                1'b0, '0);
        add_row(itp_pkg::CH_MUL,    1'b0, '0);
        add_row("c",                1'b0, '0);
        add_row(itp_pkg::CH_POW,    1'b0, '0);
        add_row("d",                1'b0, '0);
        add_row(itp_pkg::CH_SUB,    1'b0, '0);
        add_row(itp_pkg::CH_LPAREN, 1'b0, '0);
        add_row("e",                1'b0, '0);
        add_row(itp_pkg::CH_DIV,    1'b0, '0);
        add_row("f",                1'b0, '0);
        add_row(itp_pkg::CH_RPAREN, 1'b0, '0);
        add_row(itp_pkg::CH_NUL,    1'b0, '0);
        // unmatched close paren, ignored byte, then the flagged newline
        add_row(itp_pkg::CH_RPAREN, 1'b0, '0);
        add_row(8'hFF,              1'b0, '0);
        add_row(itp_pkg::CH_NUL,    1'b1, make_res(itp_pkg::CH_LF, 1'b1, 1'b1, 1'b1));
        // stray open paren is dropped silently
        add_row(itp_pkg::CH_LPAREN, 1'b0, '0);
        add_row(itp_pkg::CH_NUL,    1'b1, make_res(itp_pkg::CH_LF, 1'b1, 1'b1, 1'b0));

        handled = add_expression(1'b1);
        while (handled < TARGET_CHARS) handled += add_expression(1'b0);
        total_chars = directed_rows.size() + random_chars.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        reset_done = 1'b1;
        @(negedge i_clk);

        idx = 0;
        foreach (directed_rows[k]) begin
            set_idle_phase(idx);
            send_char(directed_rows[k].ch, directed_rows[k].typed, directed_rows[k].res);
            idx++;
        end
        foreach (random_chars[k]) begin
            set_idle_phase(idx);
            if (idx == total_chars / 2) begin
                // let the block drain completely before going on
                i_push <= 1'b0;
                @(negedge i_clk);
                while (postfix_expected.size() != 0) @(negedge i_clk);
            end
            send_char(random_chars[k], 1'b0, '0);
            idx++;
        end

        i_push <= 1'b0;
        @(negedge i_clk);
        while (postfix_expected.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
